// ----- src/esc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types, codes and helpers for the environmental sensor compensation
// pipeline.
// ---------------------------------------------------------------------------
package esc_pkg;

  // Raw codes that mark a channel as switched off
  localparam logic [23:0] RawOff24 = 24'h800000;
  localparam logic [15:0] RawOff16 = 16'h8000;

  // Wide datapath of the pressure channel
  localparam int unsigned WideW = 64;
  localparam int unsigned HalfW = WideW / 2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CfgTemp      = 3'd0,
    CfgPressLow  = 3'd1,
    CfgPressHigh = 3'd2,
    CfgPressNine = 3'd3,
    CfgHum       = 3'd4,
    CfgHumSix    = 3'd5
  } cfg_reg_t;

  // Per-reading control carried alongside the datapath
  typedef struct packed {
    logic v;
    logic tdis;
    logic pdis;
    logic hdis;
  } flags_t;

  // Signed 32-bit division by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_p2_32(input logic [31:0] x, input logic [4:0] k);
    logic [31:0] bias;
    logic [31:0] s;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    s    = x + bias;
    return 32'($signed(s) >>> k);
  endfunction

  // Arithmetic right shift of a 64-bit pattern
  function automatic logic [WideW-1:0] asr64(input logic [WideW-1:0] x, input logic [5:0] n);
    return WideW'($signed(x) >>> n);
  endfunction

endpackage

// ----- src/esc_mul64.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// esc_mul64
// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product,
// built from three 32 x 32 partial products.
// ---------------------------------------------------------------------------
module esc_mul64 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [esc_pkg::WideW-1:0]   a,
  input  logic [esc_pkg::WideW-1:0]   b,
  output logic [esc_pkg::WideW-1:0]   p
);

  localparam int unsigned W = esc_pkg::WideW;
  localparam int unsigned H = esc_pkg::HalfW;

  logic [W-1:0] ll;
  logic [H-1:0] lh;
  logic [H-1:0] hl;

  // Form partial products, then fold the cross terms into the upper half
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= W'(a[H-1:0]) * W'(b[H-1:0]);
      lh <= H'(a[H-1:0] * b[W-1:H]);
      hl <= H'(a[W-1:H] * b[H-1:0]);
      p  <= ll + {lh + hl, {H{1'b0}}};
    end
  end

endmodule

// ----- src/esc_div64.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// esc_div64
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module esc_div64 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [esc_pkg::WideW-1:0]   num,
  input  logic [esc_pkg::WideW-1:0]   den,
  output logic [esc_pkg::WideW-1:0]   quo
);

  localparam int unsigned W = esc_pkg::WideW;

  logic [W-1:0] rem [W+1];
  logic [W-1:0] nq  [W+1];
  logic [W-1:0] dv  [W+1];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dv[0]  = den;

  // One compare and subtract per stage; quotient bits fill in from the bottom
  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W:0] sh;
    logic       ge;
    assign sh = {rem[i], nq[i][W-1]};
    assign ge = sh >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? W'(sh - {1'b0, dv[i]}) : sh[W-1:0];
        nq[i+1]  <= {nq[i][W-2:0], ge};
        dv[i+1]  <= dv[i];
      end
    end
  end

  assign quo = nq[W];

endmodule

// ----- src/environmental_sensor_compensation.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// environmental_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ---------------------------------------------------------------------------
// Takes one raw reading every cycle unless a held result stalls the input,
// and returns the compensated word. The latency is set by the pressure
// channel: its 64-bit signed division runs through a 64-stage divider, and
// its 64-bit products go through two-stage multipliers. The temperature and
// humidity results are delayed to meet it. A held result freezes the pipeline.
// Calibration registers are written through the configuration port, which is
// always ready, and should be written only while the pipeline is empty.
module environmental_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] raw_temp,
  input  logic [23:0] raw_press,
  input  logic [15:0] raw_hum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] temp_centideg,
  output logic [31:0] press_q24_8,
  output logic [16:0] hum_q22_10,
  output logic        temp_valid,
  output logic        press_valid,
  output logic        hum_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned W      = esc_pkg::WideW;
  localparam int unsigned Lat    = 88;
  localparam int unsigned TDly   = Lat - 6;
  localparam int unsigned HDly   = Lat - 19;
  localparam int unsigned PpDly  = 11;
  localparam int unsigned HrDly  = 5;
  localparam int unsigned DivDly = W;
  localparam int unsigned OkDly  = Lat - 79;

  // Calibration registers
  logic [47:0] temp_cal;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [15:0] press_nine;
  logic [55:0] hum_cal;
  logic [7:0]  hum_six;

  assign cfg_ready = 1'b1;

  // Take a configuration word
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal   <= '0;
      press_lo   <= '0;
      press_hi   <= '0;
      press_nine <= '0;
      hum_cal    <= '0;
      hum_six    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (esc_pkg::cfg_reg_t'(cfg_index))
        esc_pkg::CfgTemp:      temp_cal   <= cfg_data[47:0];
        esc_pkg::CfgPressLow:  press_lo   <= cfg_data;
        esc_pkg::CfgPressHigh: press_hi   <= cfg_data;
        esc_pkg::CfgPressNine: press_nine <= cfg_data[15:0];
        esc_pkg::CfgHum:       hum_cal    <= cfg_data[55:0];
        esc_pkg::CfgHumSix:    hum_six    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Coefficients, sign- or zero-extended to the width of their channel; h4 stays raw
  logic [31:0] t1x, t2x, t3x;
  logic [W-1:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;
  logic [31:0] h1x, h2x, h3x, h5x, h6x;
  logic [11:0] h4r;

  assign t1x = {16'd0, temp_cal[15:0]};
  assign t2x = {{16{temp_cal[31]}}, temp_cal[31:16]};
  assign t3x = {{16{temp_cal[47]}}, temp_cal[47:32]};
  assign p1x = {48'd0, press_lo[15:0]};
  assign p2x = {{48{press_lo[31]}}, press_lo[31:16]};
  assign p3x = {{48{press_lo[47]}}, press_lo[47:32]};
  assign p4x = {{48{press_lo[63]}}, press_lo[63:48]};
  assign p5x = {{48{press_hi[15]}}, press_hi[15:0]};
  assign p6x = {{48{press_hi[31]}}, press_hi[31:16]};
  assign p7x = {{48{press_hi[47]}}, press_hi[47:32]};
  assign p8x = {{48{press_hi[63]}}, press_hi[63:48]};
  assign p9x = {{48{press_nine[15]}}, press_nine};
  assign h1x = {24'd0, hum_cal[7:0]};
  assign h2x = {{16{hum_cal[23]}}, hum_cal[23:8]};
  assign h3x = {24'd0, hum_cal[31:24]};
  assign h4r = hum_cal[43:32];
  assign h5x = {{20{hum_cal[55]}}, hum_cal[55:44]};
  assign h6x = {{24{hum_six[7]}}, hum_six};

  // Global advance: freeze everything while a finished word is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Control line
  esc_pkg::flags_t fl [Lat];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Lat; i++) fl[i] <= '0;
    end else if (adv) begin
      fl[0].v    <= in_valid;
      fl[0].tdis <= raw_temp == esc_pkg::RawOff24;
      fl[0].pdis <= raw_press == esc_pkg::RawOff24;
      fl[0].hdis <= raw_hum == esc_pkg::RawOff16;
      for (int i = 1; i < Lat; i++) fl[i] <= fl[i-1];
    end
  end

  // -------------------------------------------------------------------------
  // Fine temperature and temperature
  // -------------------------------------------------------------------------
  logic [19:0] adc_t;
  assign adc_t = raw_temp[23:4];

  logic [31:0] s1_tx, s1_ty, s2_m1, s2_m2, s3_ta, s3_tq, s4_m3, s4_ta, s5_tf, s6_temp;
  logic [31:0] temp_dly [TDly];
  logic [31:0] tf5;
  assign tf5 = {s5_tf[29:0], 2'b00} + s5_tf + 32'd128;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tx   <= 32'(adc_t >> 3) - {t1x[30:0], 1'b0};
      s1_ty   <= 32'(adc_t >> 4) - t1x;
      s2_m1   <= s1_tx * t2x;
      s2_m2   <= s1_ty * s1_ty;
      s3_ta   <= esc_pkg::sdiv_p2_32(s2_m1, 5'd11);
      s3_tq   <= esc_pkg::sdiv_p2_32(s2_m2, 5'd12);
      s4_m3   <= s3_tq * t3x;
      s4_ta   <= s3_ta;
      s5_tf   <= fl[3].tdis ? 32'd0 : s4_ta + esc_pkg::sdiv_p2_32(s4_m3, 5'd14);
      s6_temp <= esc_pkg::sdiv_p2_32(tf5, 5'd8);
      temp_dly[0] <= s6_temp;
      for (int i = 1; i < TDly; i++) temp_dly[i] <= temp_dly[i-1];
    end
  end

  // -------------------------------------------------------------------------
  // Pressure
  // -------------------------------------------------------------------------
  logic [W-1:0] pp_dly [PpDly];
  logic [W-1:0] s6_pa;
  logic [W-1:0] aa8, ap5_8, ap2_8, b1_10, a3_10, x13, n14;
  logic [W-1:0] s9_ap5, s10_ap5, s9_ap2, s10_ap2;
  logic [W-1:0] s11_pb, s11_px, s12_pnum, s14_pdv;
  logic [W-1:0] s15_nm, s15_dm;
  logic         s15_qneg, s15_ok;
  logic [1:0]   sd_dly [DivDly];
  logic [W-1:0] q79;
  logic [W-1:0] s80_p, s81_p13, s81_p, s82_p13, s83_p13, s82_p, s83_p, s84_p, s85_p;
  logic [W-1:0] s83_s, p8p83, s84_p8p, s85_p8p, s2_85;
  logic [W-1:0] s86_ps, s87_pf;
  logic [31:0]  s88_press;
  logic         ok_dly [OkDly];

  esc_mul64 u_mul_aa  (.clk(clk), .en(adv), .a(s6_pa),    .b(s6_pa),       .p(aa8));
  esc_mul64 u_mul_ap5 (.clk(clk), .en(adv), .a(s6_pa),    .b(p5x),         .p(ap5_8));
  esc_mul64 u_mul_ap2 (.clk(clk), .en(adv), .a(s6_pa),    .b(p2x),         .p(ap2_8));
  esc_mul64 u_mul_b1  (.clk(clk), .en(adv), .a(aa8),      .b(p6x),         .p(b1_10));
  esc_mul64 u_mul_a3  (.clk(clk), .en(adv), .a(aa8),      .b(p3x),         .p(a3_10));
  esc_mul64 u_mul_x   (.clk(clk), .en(adv), .a(s11_px),   .b(p1x),         .p(x13));
  esc_mul64 u_mul_n   (.clk(clk), .en(adv), .a(s12_pnum), .b(64'd3125),    .p(n14));
  esc_mul64 u_mul_s   (.clk(clk), .en(adv), .a(p9x),      .b(s81_p13),     .p(s83_s));
  esc_mul64 u_mul_p8  (.clk(clk), .en(adv), .a(p8x),      .b(s81_p),       .p(p8p83));
  esc_mul64 u_mul_s2  (.clk(clk), .en(adv), .a(s83_s),    .b(s83_p13),     .p(s2_85));

  esc_div64 u_div (.clk(clk), .en(adv), .num(s15_nm), .den(s15_dm), .quo(q79));

  always_ff @(posedge clk) begin
    if (adv) begin
      // Offset raw pressure, carried until the numerator is formed
      pp_dly[0] <= 64'd1048576 - W'(raw_press[23:4]);
      for (int i = 1; i < PpDly; i++) pp_dly[i] <= pp_dly[i-1];

      s6_pa    <= {{32{s5_tf[31]}}, s5_tf} - 64'd128000;
      s9_ap5   <= ap5_8;
      s10_ap5  <= s9_ap5;
      s9_ap2   <= ap2_8;
      s10_ap2  <= s9_ap2;
      s11_pb   <= b1_10 + (s10_ap5 << 17) + (p4x << 35);
      s11_px   <= esc_pkg::asr64(a3_10, 6'd8) + (s10_ap2 << 12) + (64'd1 << 47);
      s12_pnum <= (pp_dly[PpDly-1] << 31) - s11_pb;
      s14_pdv  <= esc_pkg::asr64(x13, 6'd33);

      // Split into magnitude and sign for the divider
      s15_nm   <= n14[W-1] ? W'(64'd0 - n14) : n14;
      s15_dm   <= s14_pdv[W-1] ? W'(64'd0 - s14_pdv) : s14_pdv;
      s15_qneg <= n14[W-1] ^ s14_pdv[W-1];
      s15_ok   <= !fl[13].pdis && (s14_pdv != '0);
      sd_dly[0] <= {s15_qneg, s15_ok};
      for (int i = 1; i < DivDly; i++) sd_dly[i] <= sd_dly[i-1];

      s80_p   <= sd_dly[DivDly-1][1] ? W'(64'd0 - q79) : q79;
      ok_dly[0] <= sd_dly[DivDly-1][0];
      for (int i = 1; i < OkDly; i++) ok_dly[i] <= ok_dly[i-1];

      s81_p13 <= esc_pkg::asr64(s80_p, 6'd13);
      s81_p   <= s80_p;
      s82_p13 <= s81_p13;
      s83_p13 <= s82_p13;
      s82_p   <= s81_p;
      s83_p   <= s82_p;
      s84_p   <= s83_p;
      s85_p   <= s84_p;
      s84_p8p <= p8p83;
      s85_p8p <= s84_p8p;
      s86_ps  <= s85_p + esc_pkg::asr64(s2_85, 6'd25) + esc_pkg::asr64(s85_p8p, 6'd19);
      s87_pf  <= esc_pkg::asr64(s86_ps, 6'd8) + (p7x << 4);

      // Saturate to the unsigned 32-bit range
      if (s87_pf[W-1]) begin
        s88_press <= 32'd0;
      end else if (s87_pf[W-1:32] != '0) begin
        s88_press <= 32'hFFFF_FFFF;
      end else begin
        s88_press <= s87_pf[31:0];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Humidity
  // -------------------------------------------------------------------------
  logic [15:0] hr_dly [HrDly];
  logic [31:0] s6_hdt, s6_hab;
  logic [31:0] s7_hc, s7_dh6, s7_dh3, s7_hab;
  logic [31:0] s8_he, s8_ha2, s8_hb2;
  logic [31:0] s9_hm, s9_he, s10_hc2, s10_he, s11_hp, s11_he, s12_ha3, s12_he;
  logic [31:0] s13_hbb, s14_ht, s14_hbb, s15_htt, s15_hbb, s16_hc3, s16_hbb;
  logic [31:0] s17_hch, s17_hbb, s18_he2;
  logic [16:0] s19_hum;
  logic [16:0] hum_dly [HDly];

  always_ff @(posedge clk) begin
    if (adv) begin
      hr_dly[0] <= raw_hum;
      for (int i = 1; i < HrDly; i++) hr_dly[i] <= hr_dly[i-1];

      s6_hdt  <= s5_tf - 32'd76800;
      s6_hab  <= {2'b00, hr_dly[HrDly-1], 14'd0} - {h4r, 20'd0};
      s7_hc   <= h5x * s6_hdt;
      s7_dh6  <= s6_hdt * h6x;
      s7_dh3  <= s6_hdt * h3x;
      s7_hab  <= s6_hab;
      s8_he   <= esc_pkg::sdiv_p2_32(s7_hab - s7_hc + 32'd16384, 5'd15);
      s8_ha2  <= esc_pkg::sdiv_p2_32(s7_dh6, 5'd10);
      s8_hb2  <= esc_pkg::sdiv_p2_32(s7_dh3, 5'd11) + 32'd32768;
      s9_hm   <= s8_ha2 * s8_hb2;
      s9_he   <= s8_he;
      s10_hc2 <= esc_pkg::sdiv_p2_32(s9_hm, 5'd10) + 32'd2097152;
      s10_he  <= s9_he;
      s11_hp  <= s10_hc2 * h2x;
      s11_he  <= s10_he;
      s12_ha3 <= esc_pkg::sdiv_p2_32(s11_hp + 32'd8192, 5'd14);
      s12_he  <= s11_he;
      s13_hbb <= s12_he * s12_ha3;
      s14_ht  <= esc_pkg::sdiv_p2_32(s13_hbb, 5'd15);
      s14_hbb <= s13_hbb;
      s15_htt <= s14_ht * s14_ht;
      s15_hbb <= s14_hbb;
      s16_hc3 <= esc_pkg::sdiv_p2_32(s15_htt, 5'd7);
      s16_hbb <= s15_hbb;
      s17_hch <= s16_hc3 * h1x;
      s17_hbb <= s16_hbb;
      s18_he2 <= s17_hbb - esc_pkg::sdiv_p2_32(s17_hch, 5'd4);

      // Clamp to 0..100 %RH before the final scaling
      if (s18_he2[31]) begin
        s19_hum <= 17'd0;
      end else if (s18_he2 > 32'd419430400) begin
        s19_hum <= 17'(32'd419430400 >> 12);
      end else begin
        s19_hum <= s18_he2[28:12];
      end

      hum_dly[0] <= s19_hum;
      for (int i = 1; i < HDly; i++) hum_dly[i] <= hum_dly[i-1];
    end
  end

  // -------------------------------------------------------------------------
  // Output word
  // -------------------------------------------------------------------------
  assign out_valid     = fl[Lat-1].v;
  assign temp_valid    = !fl[Lat-1].tdis;
  assign press_valid   = ok_dly[OkDly-1];
  assign hum_valid     = !fl[Lat-1].hdis;
  assign temp_centideg = fl[Lat-1].tdis ? 32'd0 : temp_dly[TDly-1];
  assign press_q24_8   = ok_dly[OkDly-1] ? s88_press : 32'd0;
  assign hum_q22_10    = fl[Lat-1].hdis ? 17'd0 : hum_dly[HDly-1];

endmodule

// ----- verif/esc_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// esc_checker
// Watches the reading, result and calibration channels of the compensation
// block. It keeps its own copy of the calibration registers and computes
// the compensated word for every accepted reading. It then compares each
// returned word, field by field, with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module esc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [23:0] raw_temp,
  input  logic [23:0] raw_press,
  input  logic [15:0] raw_hum,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] temp_centideg,
  input  logic [31:0] press_q24_8,
  input  logic [16:0] hum_q22_10,
  input  logic        temp_valid,
  input  logic        press_valid,
  input  logic        hum_valid,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        t_ok;
    logic        p_ok;
    logic        h_ok;
  } comp_word_t;

  comp_word_t  expected_words[$];
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [15:0] cal_p9;
  logic [55:0] cal_hum;
  logic [7:0]  cal_h6;

  assign pending_words = expected_words.size();

  // Signed 32-bit division by a positive constant, truncating toward zero
  function automatic logic [31:0] div32(input logic [31:0] x, input int d);
    return $signed(x) / d;
  endfunction

  function automatic logic [63:0] shr64(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  // Signed truncating 64-bit division done on magnitudes, so it wraps
  function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic [31:0] fine_temperature(input logic [23:0] raw);
    logic [31:0] adc, t1, t2, t3, a, b;
    if (raw == esc_pkg::RawOff24) return 32'd0;
    adc = {12'd0, raw[23:4]};
    t1  = {16'd0, cal_temp[15:0]};
    t2  = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3  = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a   = adc / 32'd8 - t1 * 32'd2;
    a   = div32(a * t2, 2048);
    b   = adc / 32'd16 - t1;
    b   = div32(b * b, 4096);
    b   = div32(b * t3, 16384);
    return a + b;
  endfunction

  function automatic logic [31:0] pressure_q24_8(input logic [31:0] tf,
                                                 input logic [23:0] raw,
                                                 output logic ok);
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p;
    p1 = {48'd0, cal_press_lo[15:0]};
    p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
    p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
    p4 = {{48{cal_press_lo[63]}}, cal_press_lo[63:48]};
    p5 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
    p6 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
    p7 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
    p8 = {{48{cal_press_hi[63]}}, cal_press_hi[63:48]};
    p9 = {{48{cal_p9[15]}}, cal_p9};
    ok = 1'b0;
    if (raw == esc_pkg::RawOff24) return 32'd0;
    a = {{32{tf[31]}}, tf} - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = shr64(a * a * p3, 8) + ((a * p2) << 12);
    a = shr64(((64'd1 << 47) + a) * p1, 33);
    // zero divisor
    if (a == 64'd0) return 32'd0;
    ok = 1'b1;
    p = 64'd1048576 - {44'd0, raw[23:4]};
    p = div64(((p << 31) - b) * 64'd3125, a);
    a = shr64(p9 * shr64(p, 13) * shr64(p, 13), 25);
    b = shr64(p8 * p, 19);
    p = shr64(p + a + b, 8) + (p7 << 4);
    if (p[63]) return 32'd0;
    if (p > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return p[31:0];
  endfunction

  function automatic logic [16:0] humidity_q22_10(input logic [31:0] tf,
                                                  input logic [15:0] raw);
    logic [31:0] h1, h2, h3, h4, h5, h6, d, a, b, c, e, t;
    h1 = {24'd0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'd0, cal_hum[31:24]};
    h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    h6 = {{24{cal_h6[7]}}, cal_h6};
    d = tf - 32'd76800;
    a = {16'd0, raw} * 32'd16384;
    b = h4 * 32'd1048576;
    c = h5 * d;
    e = div32(a - b - c + 32'd16384, 32768);
    a = div32(d * h6, 1024);
    b = div32(d * h3, 2048);
    c = div32(a * (b + 32'd32768), 1024) + 32'd2097152;
    a = div32(c * h2 + 32'd8192, 16384);
    b = e * a;
    t = div32(b, 32768);
    c = div32(t * t, 128);
    e = b - div32(c * h1, 16);
    // clamp to the humidity range
    if (e[31]) e = 32'd0;
    if (e > 32'd419430400) e = 32'd419430400;
    e = e / 32'd4096;
    return e[16:0];
  endfunction

  function automatic comp_word_t compensate(input logic [23:0] rt, input logic [23:0] rp,
                                            input logic [15:0] rh);
    comp_word_t  w;
    logic [31:0] tf;
    logic        pok;
    tf      = fine_temperature(rt);
    w.t_ok  = (rt != esc_pkg::RawOff24);
    w.temp  = w.t_ok ? div32(tf * 32'd5 + 32'd128, 256) : 32'd0;
    w.press = pressure_q24_8(tf, rp, pok);
    w.p_ok  = pok;
    w.h_ok  = (rh != esc_pkg::RawOff16);
    w.hum   = w.h_ok ? humidity_q22_10(tf, rh) : 17'd0;
    return w;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // Track calibration, predict readings and check returned words
  always @(posedge clk) begin
    comp_word_t w;
    if (rst) begin
      cal_temp     <= '0;
      cal_press_lo <= '0;
      cal_press_hi <= '0;
      cal_p9       <= '0;
      cal_hum      <= '0;
      cal_h6       <= '0;
      fail_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          esc_pkg::CfgTemp:      cal_temp     <= cfg_data[47:0];
          esc_pkg::CfgPressLow:  cal_press_lo <= cfg_data;
          esc_pkg::CfgPressHigh: cal_press_hi <= cfg_data;
          esc_pkg::CfgPressNine: cal_p9       <= cfg_data[15:0];
          esc_pkg::CfgHum:       cal_hum      <= cfg_data[55:0];
          esc_pkg::CfgHumSix:    cal_h6       <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_words.push_back(compensate(raw_temp, raw_press, raw_hum));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", temp_centideg, 32'd0);
        end else begin
          w = expected_words.pop_front();
          if (temp_centideg !== w.temp) report("temp_centideg", temp_centideg, w.temp);
          if (press_q24_8 !== w.press) report("press_q24_8", press_q24_8, w.press);
          if (hum_q22_10 !== w.hum) report("hum_q22_10", {15'd0, hum_q22_10}, {15'd0, w.hum});
          if (temp_valid !== w.t_ok) report("temp_valid", {31'd0, temp_valid}, {31'd0, w.t_ok});
          if (press_valid !== w.p_ok)
            report("press_valid", {31'd0, press_valid}, {31'd0, w.p_ok});
          if (hum_valid !== w.h_ok) report("hum_valid", {31'd0, hum_valid}, {31'd0, w.h_ok});
        end
      end
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the environmental sensor compensation block.
// Runs several calibration sets (reset, typical, random and extreme), each
// with a burst of readings, under random idling on both channels (none in
// the last set) and one long result hold-off that fills the pipeline.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int IdleLimit = 3000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] raw_temp;
  logic [23:0] raw_press;
  logic [15:0] raw_hum;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] temp_centideg;
  logic [31:0] press_q24_8;
  logic [16:0] hum_q22_10;
  logic        temp_valid;
  logic        press_valid;
  logic        hum_valid;
  logic        cfg_valid;
  logic        cfg_ready;
  esc_pkg::cfg_reg_t cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending_words;
  logic        quiet;
  logic        hold_req;
  int          stall_left;
  int          calm_left;
  int          idle_cycles;

  environmental_sensor_compensation i_dut (.*);

  esc_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stall bursts, calm stretches and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else if (hold_req) begin
      out_stall  <= 1'b1;
      stall_left <= 300;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end else if (quiet || calm_left > 0) begin
      out_stall <= 1'b0;
      if (calm_left > 0) calm_left <= calm_left - 1;
    end else if ($urandom_range(39) == 0) begin
      calm_left <= $urandom_range(150, 50);
    end else if ($urandom_range(7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(15, 1);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_cal(input esc_pkg::cfg_reg_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_calibration(input logic [47:0] t, input logic [63:0] plo,
                                  input logic [63:0] phi, input logic [15:0] p9,
                                  input logic [55:0] h, input logic [7:0] h6);
    write_cal(esc_pkg::CfgTemp, {16'd0, t});
    write_cal(esc_pkg::CfgPressLow, plo);
    write_cal(esc_pkg::CfgPressHigh, phi);
    write_cal(esc_pkg::CfgPressNine, {48'd0, p9});
    write_cal(esc_pkg::CfgHum, {8'd0, h});
    write_cal(esc_pkg::CfgHumSix, {56'd0, h6});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one reading, hold it until taken, then maybe drop valid for a gap
  task automatic send_reading(input logic [23:0] t, input logic [23:0] p,
                              input logic [15:0] h);
    in_valid  <= 1'b1;
    raw_temp  <= t;
    raw_press <= p;
    raw_hum   <= h;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (!quiet && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    logic [23:0] t, p;
    logic [15:0] h;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          t = 24'($urandom);
          p = 24'($urandom);
          h = 16'($urandom);
        end
        3: begin
          t = ($urandom_range(1) == 0) ? esc_pkg::RawOff24 : 24'($urandom);
          p = ($urandom_range(1) == 0) ? esc_pkg::RawOff24 :
                                         24'($urandom_range(458751, 327680));
          h = ($urandom_range(1) == 0) ? esc_pkg::RawOff16 : 16'($urandom);
        end
        default: begin
          // plausible readings around room conditions
          t = 24'($urandom_range(655359, 393216));
          p = 24'($urandom_range(458751, 327680));
          h = 16'($urandom_range(36863, 20480));
        end
      endcase
      send_reading(t, p, h);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    raw_temp  <= '0;
    raw_press <= '0;
    raw_hum   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= esc_pkg::CfgTemp;
    cfg_data  <= '0;
    quiet     <= 1'b0;
    hold_req  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: zero pressure divisor everywhere
    send_reading(24'h000000, 24'h000000, 16'h0000);
    send_reading(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_reading(esc_pkg::RawOff24, esc_pkg::RawOff24, esc_pkg::RawOff16);
    drain();

    // Typical calibration with field extremes and disabled channels
    load_calibration({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000,
                     {12'd50, 12'd313, 8'd0, 16'd362, 8'd75}, 8'd30);
    send_reading(24'h7EED0, 24'h655A0, 16'h6C5A);
    send_reading(24'h000000, 24'h655A0, 16'h6C5A);
    send_reading(24'hFFFFFF, 24'h655A0, 16'h6C5A);
    send_reading(esc_pkg::RawOff24, 24'h655A0, 16'h6C5A);
    send_reading(24'h7EED0, 24'h000000, 16'h6C5A);
    send_reading(24'h7EED0, 24'hFFFFFF, 16'h6C5A);
    send_reading(24'h7EED0, esc_pkg::RawOff24, 16'h6C5A);
    send_reading(24'h7EED0, 24'h655A0, 16'h0000);
    send_reading(24'h7EED0, 24'h655A0, 16'hFFFF);
    send_reading(24'h7EED0, 24'h655A0, esc_pkg::RawOff16);
    send_reading(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
    send_reading(24'h800001, 24'h800001, 16'h8001);
    send_reading(24'hFFFFFF, 24'h000000, 16'hFFFF);
    send_reading(24'h000000, 24'hFFFFFF, 16'h0000);
    send_reading(esc_pkg::RawOff24, esc_pkg::RawOff24, 16'hFFFF);
    drain();

    // Typical calibration, random readings, with one long result hold-off
    send_random(20);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_random(110);
    drain();

    // Random calibration
    load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom),
                     56'({$urandom, $urandom}), 8'($urandom));
    send_random(100);
    drain();

    // All ones
    load_calibration('1, '1, '1, '1, '1, '1);
    send_random(60);
    drain();

    // Most negative signed fields, largest unsigned ones
    load_calibration({16'h8000, 16'h8000, 16'hFFFF},
                     {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                     {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000,
                     {12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF}, 8'h80);
    send_random(60);
    drain();

    // Most positive signed fields
    load_calibration({16'h7FFF, 16'h7FFF, 16'h0001},
                     {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                     {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF,
                     {12'h7FF, 12'h7FF, 8'h00, 16'h7FFF, 8'h00}, 8'h7F);
    send_random(60);
    drain();

    // Random calibration again, no idling on either side
    load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom),
                     56'({$urandom, $urandom}), 8'($urandom));
    quiet <= 1'b1;
    @(posedge clk);
    while (stall_left != 0) @(posedge clk);
    send_random(120);
    drain();

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
